// ===== src/oqd_pkg.sv =====
// Shared constants, codes and types of the ordered queue with delete by value.
package oqd_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned OCNT_W  = 5;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OUT_W   = 8;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOMATCH = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic {
    OP_PUSH   = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp;    // register match flag
    logic apply;  // commit push or shift
    logic push;   // operation is a push
  } cell_ctrl_t;

endpackage

// ===== src/oqd_cell.sv =====
// One storage cell of the queue: holds an entry, compares it, shifts toward the head.
module oqd_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  oqd_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              valid_i,
  input  logic                              tail_i,
  input  logic [oqd_pkg::DATA_W-1:0]        key_i,
  input  logic [oqd_pkg::DATA_W-1:0]        next_entry_i,
  input  logic                              found_i,
  output logic [oqd_pkg::DATA_W-1:0]        entry_o,
  output logic                              found_o
);

  logic [oqd_pkg::DATA_W-1:0] entry_q;
  logic                       match_q;

  // a match here or nearer the head closes the gap at this cell
  assign found_o = found_i | match_q;
  assign entry_o = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      match_q <= valid_i & (entry_q == key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply) begin
      if (ctrl_i.push) begin
        if (tail_i) begin
          entry_q <= key_i;
        end
      end else if (found_o) begin
        entry_q <= next_entry_i;
      end
    end
  end

endmodule

// ===== src/ordered_queue_delete_by_value_unit.sv =====
// Top level of the ordered queue with delete by value: handshake, control and cell row.
//
// Usage:
//   Input channel (s_axis_*): one transaction carries one operation. tuser holds
//   the operation (0 push value at the tail, 1 remove the first entry equal to the
//   value, searched from the head); tdata holds the signed 32-bit value.
//   Output channel (m_axis_*): exactly one result transaction per operation, in
//   order. tdata bits [1:0] give the status (0 ok, 1 no match, 2 full, push
//   refused) and bits [6:2] the entry count after the operation.
//   Operation flow: at the edge that accepts an operation every cell
//   registers whether its entry matches the key. Once the output register
//   is free, the first-match flag ripples along the row, the row shifts (or
//   the tail loads) and the result is registered, raising m_axis_tvalid.
//   s_axis_tready is low while an operation is pending, so a new operation
//   is not accepted until the pending one has committed; the registered
//   match flag sets this.
//   Reset: the store is emptied (count zero, no pending result). Entry contents
//   are not cleared; only positions below the count are ever read.
//   Stall: the result waits in the output register while m_axis_tready is low.
//   A new operation is still taken and compared, then held until the output
//   register is free.
module ordered_queue_delete_by_value_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // [31:0] value
  input  logic                        s_axis_tuser,  // [0] op
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [oqd_pkg::OUT_W-1:0]   m_axis_tdata   // [1:0] status, [6:2] entry_count, [7] zero
);

  localparam int unsigned DEPTH = oqd_pkg::DEPTH;
  localparam int unsigned CNT_W = oqd_pkg::CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e                        state_q, state_d;
  logic [oqd_pkg::DATA_W-1:0]    key_q;
  logic                          op_q;
  logic [CNT_W-1:0]              count_q, count_d;
  logic                          out_valid_q;
  oqd_pkg::status_e              status_q, status_d;
  logic [oqd_pkg::OCNT_W-1:0]    out_count_q;

  logic                          in_fire;
  logic                          commit;
  logic                          is_push;
  logic                          full;
  oqd_pkg::cell_ctrl_t           ctrl;

  logic [oqd_pkg::DATA_W-1:0]    entry   [DEPTH];
  logic [DEPTH:0]                found;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  // commit once compare is done and the output register can take the result
  assign commit        = (state_q == ST_EXEC) & (~out_valid_q | m_axis_tready);
  assign is_push       = (op_q == oqd_pkg::OP_PUSH);
  assign full          = (count_q == CNT_W'(DEPTH));

  assign ctrl.cmp   = in_fire;
  assign ctrl.apply = commit;
  assign ctrl.push  = is_push;

  // first-match flag ripples from head to tail
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [oqd_pkg::DATA_W-1:0] next_entry;
    if (i == DEPTH - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end

    oqd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .valid_i      (CNT_W'(i) < count_q),
      .tail_i       (count_q == CNT_W'(i)),
      .key_i        (in_fire ? s_axis_tdata : key_q),
      .next_entry_i (next_entry),
      .found_i      (found[i]),
      .entry_o      (entry[i]),
      .found_o      (found[i+1])
    );
  end

  // status and new count of the operation being committed
  always_comb begin
    count_d  = count_q;
    status_d = oqd_pkg::STATUS_OK;
    if (is_push) begin
      if (full) begin
        status_d = oqd_pkg::STATUS_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (found[DEPTH]) begin
        count_d = count_q - CNT_W'(1);
      end else begin
        status_d = oqd_pkg::STATUS_NOMATCH;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        // drop the result once the receiver takes it
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the operation from acceptance until it commits
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q <= s_axis_tdata;
      op_q  <= s_axis_tuser;
    end
    if (commit) begin
      status_q    <= status_d;
      out_count_q <= oqd_pkg::OCNT_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, status_q};

endmodule
